// ===== rtl/adc_decimating_fir_calibrate_assert.svh =====
`ifndef ADC_DECIMATING_FIR_CALIBRATE_ASSERT_SVH
`define ADC_DECIMATING_FIR_CALIBRATE_ASSERT_SVH

// implication in the same cycle, off while in reset
`define ADFC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication in the next cycle, off while in reset
`define ADFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition that holds in the cycle after a reset cycle
`define ADFC_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

// ===== rtl/adfc_pkg.sv =====
`timescale 1ns / 1ps

package adfc_pkg;

  // sizes
  localparam int CHANNELS       = 8;
  localparam int MAX_OVERSAMPLE = 64;
  localparam int CH_W           = 3;
  localparam int POS_W          = 6;
  localparam int VAL_W          = 16;
  localparam int SCALE_W        = 32;
  localparam int ACC_W          = 48;
  localparam int CNT_W          = 7;
  localparam int NRM_W          = 16;
  localparam int OUT_W          = 32;
  localparam int FUNC_W         = 2;
  localparam int COEF_AW        = $clog2(MAX_OVERSAMPLE);

  // multiply and divide unit
  localparam int MUL_CHUNK = 16;
  localparam int MUL_STEPS = ACC_W / MUL_CHUNK;
  localparam int PP_W      = MUL_CHUNK + SCALE_W;
  localparam int PROD_W    = ACC_W + SCALE_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // item queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // range limits
  localparam logic [CH_W:0]  CH_LIMIT  = (CH_W + 1)'(CHANNELS);
  localparam logic [POS_W:0] POS_LIMIT = (POS_W + 1)'(MAX_OVERSAMPLE);

  // channel whose result is negated
  localparam logic [CH_W-1:0] CH_NEGATED = 3'd4;

  // func codes
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CAL    = 2'd2;

  // register bus
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_OVERSAMPLE = 1'b0;
  localparam logic REG_NORMALIZER = 1'b1;

  // result limits
  localparam logic [OUT_W-1:0] LIM_POS = 32'h7fff_ffff;
  localparam logic [OUT_W-1:0] LIM_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    K_COEF,
    K_CAL,
    K_SAMPLE
  } kind_t;

  // one queued item after classification
  typedef struct packed {
    kind_t                     kind;
    logic                      last;
    logic [POS_W-1:0]          pos;
    logic [CH_W-1:0]           ch;
    logic signed [VAL_W-1:0]   value;
    logic signed [SCALE_W-1:0] scale_word;
  } q_entry_t;

  // block-end job for the scaling unit
  typedef struct packed {
    logic signed [ACC_W-1:0]   acc;
    logic signed [SCALE_W-1:0] scale;
    logic [CH_W-1:0]           ch;
  } job_t;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MAC  = 4'b0010,
    B_ACC  = 4'b0100,
    B_SEND = 4'b1000
  } back_state_t;

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_ABS  = 5'b00010,
    SC_MUL  = 5'b00100,
    SC_DIV  = 5'b01000,
    SC_DONE = 5'b10000
  } sc_state_t;

endpackage

// ===== rtl/adc_decimating_fir_calibrate.sv =====
`timescale 1ns / 1ps
// load items are taken by the back end in its idle state once queued; a sample steps through read, multiply and add
// a block-end sample then goes to the scaling unit: 3 partial-product steps, then the 80-step divider
// inputs keep queueing while the divider runs, until the two-entry queue is full
// synchronous reset: accumulators read as zero, registers go to 1, queue and outputs empty

module adc_decimating_fir_calibrate import adfc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FUNC_W-1:0]         func,
  input  logic [POS_W-1:0]          position,
  input  logic [CH_W-1:0]           channel,
  input  logic signed [VAL_W-1:0]   value,
  input  logic signed [SCALE_W-1:0] scale_word,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CH_W-1:0]           out_channel,
  output logic signed [OUT_W-1:0]   filtered,
  output logic                      saturated
);

  logic [CNT_W-1:0] oversample_count;
  logic [NRM_W-1:0] normalizer;
  logic [CNT_W-1:0] cnt_eff;
  logic [NRM_W-1:0] nrm_eff;
  logic             reg_idx;
  logic             q_valid;
  q_entry_t         q_head;
  logic             q_pop;
  logic             job_valid;
  job_t             job;
  logic             job_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cnt_eff = (oversample_count == '0) ? CNT_W'(1) : oversample_count;
  assign nrm_eff = (normalizer == '0) ? NRM_W'(1) : normalizer;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      oversample_count <= CNT_W'(1);
      normalizer       <= NRM_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_OVERSAMPLE: oversample_count <= pwdata[CNT_W-1:0];
        REG_NORMALIZER: normalizer       <= pwdata[NRM_W-1:0];
        default:        normalizer       <= normalizer;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (reg_idx)
      REG_OVERSAMPLE: prdata = APB_DW'(oversample_count);
      REG_NORMALIZER: prdata = APB_DW'(normalizer);
      default:        prdata = '0;
    endcase
  end

  adfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .position   (position),
    .channel    (channel),
    .value      (value),
    .scale_word (scale_word),
    .cnt_eff    (cnt_eff),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  adfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready)
  );

  adfc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (job),
    .job_ready   (job_ready),
    .nrm_eff     (nrm_eff),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .filtered    (filtered),
    .saturated   (saturated)
  );

endmodule

// ===== rtl/adfc_ram.sv =====
`timescale 1ns / 1ps

module adfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/adfc_front.sv =====
`timescale 1ns / 1ps

module adfc_front import adfc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic [POS_W-1:0]         position,
  input  logic [CH_W-1:0]          channel,
  input  logic signed [VAL_W-1:0]  value,
  input  logic signed [SCALE_W-1:0] scale_word,
  input  logic [CNT_W-1:0]         cnt_eff,
  output logic                     q_valid,
  output q_entry_t                 q_head,
  input  logic                     q_pop
);

  q_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  q_entry_t          cls;
  logic              keep;
  logic              push;
  logic              ch_ok;
  logic              pos_ok;

  // classify the incoming item and drop what has no effect
  always_comb begin
    ch_ok  = {1'b0, channel} < CH_LIMIT;
    pos_ok = ({1'b0, position} < POS_LIMIT) && ({1'b0, position} < cnt_eff);
    cls.pos        = position;
    cls.ch         = channel;
    cls.value      = value;
    cls.scale_word = scale_word;
    cls.last       = ({1'b0, position} == (cnt_eff - 7'd1));
    cls.kind       = K_SAMPLE;
    keep           = 1'b0;
    unique case (func)
      FUNC_SAMPLE: begin
        cls.kind = K_SAMPLE;
        keep     = ch_ok && pos_ok;
      end
      FUNC_COEF: begin
        cls.kind = K_COEF;
        keep     = {1'b0, position} < POS_LIMIT;
      end
      FUNC_CAL: begin
        cls.kind = K_CAL;
        keep     = ch_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = (count != (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != '0);
  assign q_head   = entries[rptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= cls;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/adfc_back.sv =====
`timescale 1ns / 1ps

module adfc_back import adfc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_valid,
  input  q_entry_t q_head,
  output logic     q_pop,
  output logic     job_valid,
  output job_t     job,
  input  logic     job_ready
);

  back_state_t               state;
  back_state_t               state_next;
  logic signed [VAL_W-1:0]   bias [CHANNELS];
  logic signed [SCALE_W-1:0] scale [CHANNELS];
  logic signed [ACC_W-1:0]   acc [CHANNELS];
  logic [CHANNELS-1:0]       acc_valid;
  logic [CH_W-1:0]           cur_ch;
  logic signed [VAL_W-1:0]   cur_val;
  logic                      cur_last;
  logic signed [VAL_W-1:0]   coef;
  logic signed [VAL_W:0]     sum;
  logic signed [2*VAL_W:0]   prod;
  logic signed [ACC_W-1:0]   acc_cur;
  logic signed [ACC_W-1:0]   acc_new;
  logic                      coef_we;

  assign q_pop     = (state == B_IDLE) && q_valid;
  assign coef_we   = q_pop && (q_head.kind == K_COEF);
  assign job_valid = (state == B_SEND);

  // coefficient table
  adfc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_OVERSAMPLE)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (q_head.pos[COEF_AW-1:0]),
    .wdata (q_head.value),
    .raddr (q_head.pos[COEF_AW-1:0]),
    .rdata (coef)
  );

  // bias plus sample, and the running sum of the channel
  always_comb begin
    sum     = {cur_val[VAL_W-1], cur_val} + {bias[cur_ch][VAL_W-1], bias[cur_ch]};
    acc_cur = acc_valid[cur_ch] ? acc[cur_ch] : '0;
    acc_new = acc_cur + {{(ACC_W - 2*VAL_W - 1){prod[2*VAL_W]}}, prod};
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid && (q_head.kind == K_SAMPLE)) begin
          state_next = B_MAC;
        end
      end
      B_MAC: begin
        state_next = B_ACC;
      end
      B_ACC: begin
        state_next = cur_last ? B_SEND : B_IDLE;
      end
      B_SEND: begin
        if (job_ready) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      acc_valid <= '0;
    end else begin
      state <= state_next;
      if (state == B_ACC) begin
        acc_valid[cur_ch] <= !cur_last;
      end
    end
  end

  // calibration tables, current item, product and accumulators
  always_ff @(posedge clk) begin
    if (q_pop && (q_head.kind == K_CAL)) begin
      bias[q_head.ch]  <= q_head.value;
      scale[q_head.ch] <= q_head.scale_word;
    end
    if (q_pop && (q_head.kind == K_SAMPLE)) begin
      cur_ch   <= q_head.ch;
      cur_val  <= q_head.value;
      cur_last <= q_head.last;
    end
    if (state == B_MAC) begin
      prod <= sum * coef;
    end
    if (state == B_ACC) begin
      acc[cur_ch] <= acc_new;
      job.acc     <= acc_new;
      job.scale   <= scale[cur_ch];
      job.ch      <= cur_ch;
    end
  end

endmodule

// ===== rtl/adfc_scale.sv =====
`timescale 1ns / 1ps

module adfc_scale import adfc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  input  job_t                    job,
  output logic                    job_ready,
  input  logic [NRM_W-1:0]        nrm_eff,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CH_W-1:0]         out_channel,
  output logic signed [OUT_W-1:0] filtered,
  output logic                    saturated
);

  sc_state_t           state;
  sc_state_t           state_next;
  job_t                cur;
  logic [ACC_W-1:0]    a_sh;
  logic [SCALE_W-1:0]  s_mag;
  logic                neg;
  logic [PROD_W-1:0]   prod;
  logic [STEP_W-1:0]   step;
  logic [NRM_W-1:0]    rem;
  logic [OUT_W-1:0]    q_lo;
  logic                q_hi;
  logic [PP_W-1:0]     pp;
  logic [NRM_W:0]      trial;
  logic [NRM_W:0]      diff;
  logic                ge;
  logic [OUT_W-1:0]    lim;
  logic                over;
  logic [OUT_W-1:0]    mag;
  logic                out_free;

  assign job_ready = (state == SC_IDLE);
  assign out_free  = !out_valid || out_ready;

  // one partial product and one divider step
  always_comb begin
    pp    = a_sh[ACC_W-1 -: MUL_CHUNK] * s_mag;
    trial = {rem, prod[PROD_W-1]};
    diff  = trial - {1'b0, nrm_eff};
    ge    = (trial >= {1'b0, nrm_eff});
  end

  // clip and sign
  always_comb begin
    lim  = neg ? LIM_NEG : LIM_POS;
    over = q_hi || (q_lo > lim);
    mag  = over ? lim : q_lo;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      SC_IDLE: begin
        if (job_valid) begin
          state_next = SC_ABS;
        end
      end
      SC_ABS: begin
        state_next = SC_MUL;
      end
      SC_MUL: begin
        if (step == STEP_W'(MUL_STEPS - 1)) begin
          state_next = SC_DIV;
        end
      end
      SC_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = SC_DONE;
        end
      end
      SC_DONE: begin
        if (out_free) begin
          state_next = SC_IDLE;
        end
      end
      default: begin
        state_next = SC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SC_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == SC_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath: magnitudes, shift-add product, restoring division
  always_ff @(posedge clk) begin
    unique case (state)
      SC_IDLE: begin
        if (job_valid) begin
          cur <= job;
        end
      end
      SC_ABS: begin
        a_sh  <= cur.acc[ACC_W-1] ? (~cur.acc + 1'b1) : cur.acc;
        s_mag <= cur.scale[SCALE_W-1] ? (~cur.scale + 1'b1) : cur.scale;
        neg   <= (cur.acc[ACC_W-1] ^ cur.scale[SCALE_W-1]) ^ (cur.ch == CH_NEGATED);
        prod  <= '0;
        step  <= '0;
      end
      SC_MUL: begin
        prod <= (prod << MUL_CHUNK) + PROD_W'(pp);
        a_sh <= a_sh << MUL_CHUNK;
        if (step == STEP_W'(MUL_STEPS - 1)) begin
          step <= '0;
          rem  <= '0;
          q_lo <= '0;
          q_hi <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
      SC_DIV: begin
        rem  <= ge ? diff[NRM_W-1:0] : trial[NRM_W-1:0];
        prod <= prod << 1;
        q_lo <= {q_lo[OUT_W-2:0], ge};
        q_hi <= q_hi | q_lo[OUT_W-1];
        step <= step + 1'b1;
      end
      SC_DONE: begin
        if (out_free) begin
          out_channel <= cur.ch;
          filtered    <= neg ? (~mag + 1'b1) : mag;
          saturated   <= over;
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

// ===== rtl/adfc_checker.sv =====
`timescale 1ns / 1ps
`include "adc_decimating_fir_calibrate_assert.svh"

module adfc_checker import adfc_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [CH_W-1:0]           out_channel,
  input logic signed [OUT_W-1:0]   filtered,
  input logic                      saturated
);

  // a stalled result holds
  `ADFC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered) && $stable(out_channel) && $stable(saturated), "stalled result changed")

  // a clipped result sits at one of the two limits
  `ADFC_ASSERT_NOW(a_sat_limit, out_valid && saturated, filtered == LIM_POS || filtered == LIM_NEG, "clipped result off the limits")

  // no result right after reset
  `ADFC_ASSERT_RESET(a_rst_out, !out_valid, "result valid after reset")

  // empty queue takes items right after reset
  `ADFC_ASSERT_RESET(a_rst_in, in_ready, "input not ready after reset")

endmodule

bind adc_decimating_fir_calibrate adfc_checker u_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench import adfc_pkg::*; ;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES   = 800;
  localparam int TARGET_ITEMS  = 1700;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // one input item and one filtered output
  typedef struct {
    logic [FUNC_W-1:0]         op;
    logic [POS_W-1:0]          pos;
    logic [CH_W-1:0]           ch;
    logic signed [VAL_W-1:0]   val;
    logic signed [SCALE_W-1:0] sw;
  } fir_item_t;

  typedef struct {
    logic [CH_W-1:0]         ch;
    logic signed [OUT_W-1:0] filtered;
    logic                    sat;
  } fir_out_t;

  // tracks filter state and the outputs still owed by the block
  class decim_scoreboard;
    logic signed [ACC_W-1:0]   acc_mem   [CHANNELS];
    logic signed [VAL_W-1:0]   coef_tab  [MAX_OVERSAMPLE];
    logic signed [VAL_W-1:0]   bias_tab  [CHANNELS];
    logic signed [SCALE_W-1:0] scale_tab [CHANNELS];
    logic [CNT_W-1:0]          os_count;
    logic [NRM_W-1:0]          norm;
    fir_out_t                  expected_outputs [$];
    int                        mismatches;
    int                        outputs_seen;
    int                        saturations;

    function new();
      foreach (acc_mem[i]) acc_mem[i] = '0;
      foreach (coef_tab[i]) coef_tab[i] = '0;
      foreach (bias_tab[i]) bias_tab[i] = '0;
      foreach (scale_tab[i]) scale_tab[i] = '0;
      os_count = 1;
      norm = 1;
      mismatches = 0;
      outputs_seen = 0;
      saturations = 0;
    endfunction

    function void set_register(logic idx, logic [APB_DW-1:0] data);
      if (idx == REG_OVERSAMPLE) os_count = data[CNT_W-1:0];
      else norm = data[NRM_W-1:0];
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction

    // apply one accepted item and queue the output it causes, if any
    function void note_item(fir_item_t it);
      longint term, acc_s, sc;
      longint unsigned cnt, nrm, a, s, q, r, m, lim, res;
      bit neg, sat;
      fir_out_t o;
      case (it.op)
        FUNC_COEF: coef_tab[it.pos] = it.val;
        FUNC_CAL: begin
          bias_tab[it.ch] = it.val;
          scale_tab[it.ch] = it.sw;
        end
        FUNC_SAMPLE: begin
          cnt = (os_count == 0) ? 1 : os_count;
          nrm = (norm == 0) ? 1 : norm;
          if (it.pos < cnt) begin
            term = (longint'(it.val) + longint'(bias_tab[it.ch])) * longint'(coef_tab[it.pos]);
            acc_mem[it.ch] = acc_mem[it.ch] + term[ACC_W-1:0];
            if (it.pos == cnt - 1) begin
              acc_s = acc_mem[it.ch];
              acc_mem[it.ch] = '0;
              sc = scale_tab[it.ch];
              neg = (acc_s < 0) != (sc < 0);
              if (it.ch == CH_NEGATED) neg = !neg;
              a = (acc_s < 0) ? -acc_s : acc_s;
              s = (sc < 0) ? -sc : sc;
              q = a / nrm;
              r = a % nrm;
              lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
              sat = 1'b0;
              // quotient too big for any nonzero scale: clip right away
              if (s != 0 && q >= 64'h1_0000_0000) begin
                m = lim;
                sat = 1'b1;
              end else begin
                m = q * s + (r * s) / nrm;
                if (m > lim) begin
                  m = lim;
                  sat = 1'b1;
                end
              end
              res = neg ? (64'd0 - m) : m;
              o.ch = it.ch;
              o.filtered = res[OUT_W-1:0];
              o.sat = sat;
              expected_outputs.push_back(o);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // compare one output with the oldest one owed
    function void check_output(fir_out_t got);
      fir_out_t want;
      outputs_seen++;
      if (got.sat) saturations++;
      if (expected_outputs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected output: ch %0d filtered %0d sat %0b",
                   got.ch, got.filtered, got.sat);
        mismatches++;
        return;
      end
      want = expected_outputs.pop_front();
      if (got.ch !== want.ch || got.filtered !== want.filtered || got.sat !== want.sat) begin
        if (mismatches < 10)
          $display("mismatch on output %0d: expected ch %0d filtered %0d sat %0b, got ch %0d filtered %0d sat %0b",
                   outputs_seen, want.ch, want.filtered, want.sat,
                   got.ch, got.filtered, got.sat);
        mismatches++;
      end
    endfunction

    function void leftover();
      if (expected_outputs.size() != 0) begin
        $display("%0d expected outputs never arrived", expected_outputs.size());
        mismatches += expected_outputs.size();
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      psel, penable, pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;
  logic                      in_valid, in_ready;
  logic [FUNC_W-1:0]         func;
  logic [POS_W-1:0]          position;
  logic [CH_W-1:0]           channel;
  logic signed [VAL_W-1:0]   value;
  logic signed [SCALE_W-1:0] scale_word;
  logic                      out_valid, out_ready;
  logic [CH_W-1:0]           out_channel;
  logic signed [OUT_W-1:0]   filtered;
  logic                      saturated;

  decim_scoreboard sb;
  int cycle_count = 0;
  int total_items = 0;
  int useful_items = 0;
  int burst_left = 0;
  bit bursty = 1'b0;
  int recv_mode = 0;
  int holds_requested = 0;
  logic [CNT_W-1:0] cur_count = 1;

  adc_decimating_fir_calibrate dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // watch both handshakes
  always @(posedge clk) begin
    fir_item_t it;
    fir_out_t o;
    if (!rst) begin
      if (in_valid && in_ready) begin
        it.op = func;
        it.pos = position;
        it.ch = channel;
        it.val = value;
        it.sw = scale_word;
        sb.note_item(it);
      end
      if (out_valid && out_ready) begin
        o.ch = out_channel;
        o.filtered = filtered;
        o.sat = saturated;
        sb.check_output(o);
      end
    end
  end

  // output side: stall pattern per phase, plus requested long hold-offs
  initial begin : receiver
    int holds_done;
    int tick;
    holds_done = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_requested) begin
        holds_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      tick++;
      case (recv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 9) < 7);
        2: out_ready <= ((tick % 11) < 6);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  function automatic fir_item_t make_item(logic [FUNC_W-1:0] op, int pos, int ch,
                                          logic [VAL_W-1:0] val, logic [SCALE_W-1:0] sw);
    fir_item_t it;
    it.op = op;
    it.pos = POS_W'(pos);
    it.ch = CH_W'(ch);
    it.val = val;
    it.sw = sw;
    return it;
  endfunction

  function automatic logic [VAL_W-1:0] rand_sample();
    if ($urandom_range(0, 9) < 8) return VAL_W'($urandom_range(0, 4095));
    return VAL_W'($urandom());
  endfunction

  function automatic logic [VAL_W-1:0] rand_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return VAL_W'($urandom_range(0, 64));
    if (r < 80) return VAL_W'($urandom_range(0, 256) - 128);
    return VAL_W'($urandom());
  endfunction

  function automatic logic [VAL_W-1:0] rand_bias();
    if ($urandom_range(0, 9) < 7) return VAL_W'($urandom_range(0, 4095) - 2048);
    return VAL_W'($urandom());
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return SCALE_W'($urandom_range(0, 1 << 18) - (1 << 17));
    if (r < 70) return SCALE_W'($urandom_range(0, 1 << 24) - (1 << 23));
    if (r < 76) return 32'h7fff_ffff;
    if (r < 82) return 32'h8000_0000;
    if (r < 86) return '0;
    return $urandom();
  endfunction

  // offer one item from a falling edge, return at the falling edge after acceptance
  task automatic send_item(input fir_item_t it);
    if (bursty && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8))
        @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= it.op;
    position <= it.pos;
    channel <= it.ch;
    value <= it.val;
    scale_word <= it.sw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    total_items++;
    if (it.op == FUNC_COEF || it.op == FUNC_CAL ||
        (it.op == FUNC_SAMPLE && it.pos < ((cur_count == 0) ? 1 : cur_count)))
      useful_items++;
  endtask

  // stop offering items until every owed output is out, then let the block settle
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic apb_write(input logic idx, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * int'(idx));
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CNT_W-1:0] cnt, input logic [NRM_W-1:0] nrm);
    wait_drained(SETTLE_CYCLES);
    apb_write(REG_OVERSAMPLE, APB_DW'(cnt));
    apb_write(REG_NORMALIZER, APB_DW'(nrm));
    cur_count = cnt;
  endtask

  initial begin
    int phase_no, budget, phase_start, r, nch, base_ch, blk, stop_at, eff;
    bit paused;
    logic [CNT_W-1:0] cnt_sel;
    logic [NRM_W-1:0] nrm_sel;

    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    func = '0;
    position = '0;
    channel = '0;
    value = '0;
    scale_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes at reset settings, negated channel, zero scale, ignored items
    send_item(make_item(FUNC_COEF, 0, 0, 16'sd32767, '0));
    send_item(make_item(FUNC_COEF, 63, 0, 16'h8000, '0));
    send_item(make_item(FUNC_CAL, 0, 0, 16'd0, 32'h0001_0000));
    send_item(make_item(FUNC_CAL, 0, 4, 16'd100, 32'h0001_0000));
    send_item(make_item(FUNC_CAL, 0, 1, 16'h8000, 32'h8000_0000));
    send_item(make_item(FUNC_CAL, 0, 7, 16'h7fff, 32'h7fff_ffff));
    send_item(make_item(FUNC_CAL, 0, 2, 16'd5, 32'h0000_0000));
    send_item(make_item(FUNC_CAL, 0, 3, 16'hf800, 32'h0000_0100));
    send_item(make_item(FUNC_SAMPLE, 0, 0, 16'h7fff, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 0, 16'h8000, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 4, 16'd1000, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 1, 16'h8000, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 7, 16'h7fff, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 2, 16'hffff, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 3, 16'd2047, $urandom()));
    // position past the block length is dropped
    send_item(make_item(FUNC_SAMPLE, 5, 0, 16'd1234, $urandom()));
    send_item(make_item(FUNC_UNUSED, $urandom(), $urandom(), $urandom(), $urandom()));
    // zero count and zero normalizer both act as one
    configure(0, 0);
    send_item(make_item(FUNC_SAMPLE, 0, 4, 16'd0, $urandom()));
    // truncation toward zero on a negated result
    configure(2, 3);
    send_item(make_item(FUNC_COEF, 1, 0, 16'hfff9, '0));
    send_item(make_item(FUNC_CAL, 0, 4, 16'd3, 32'h0000_8000));
    send_item(make_item(FUNC_SAMPLE, 0, 4, 16'd2, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 1, 4, 16'd10, $urandom()));
    // count above the table size: the last position never comes
    configure(127, 1);
    send_item(make_item(FUNC_SAMPLE, 63, 0, 16'd1, $urandom()));
    send_item(make_item(FUNC_SAMPLE, 0, 0, 16'd1, $urandom()));

    // fill every table entry before random samples read them
    bursty = 1'b1;
    recv_mode = 1;
    for (int i = 0; i < MAX_OVERSAMPLE; i++)
      send_item(make_item(FUNC_COEF, i, 0, rand_coef(), $urandom()));
    for (int i = 0; i < CHANNELS; i++)
      send_item(make_item(FUNC_CAL, $urandom(), i, rand_bias(), rand_scale()));

    // random phases, each with its own settings and idle pattern
    phase_no = 0;
    while (useful_items < TARGET_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 40) cnt_sel = $urandom_range(1, 4);
      else if (r < 60) cnt_sel = $urandom_range(5, 16);
      else if (r < 70) cnt_sel = 64;
      else if (r < 78) cnt_sel = 0;
      else if (r < 85) cnt_sel = $urandom_range(65, 127);
      else cnt_sel = $urandom_range(17, 63);
      r = $urandom_range(0, 99);
      if (r < 25) nrm_sel = 1;
      else if (r < 35) nrm_sel = 0;
      else if (r < 45) nrm_sel = 16'hffff;
      else if (r < 70) nrm_sel = $urandom_range(2, 300);
      else nrm_sel = $urandom_range(1, 65535);
      case (phase_no)
        0: begin cnt_sel = 64; nrm_sel = 16'hffff; end
        1: begin cnt_sel = 1; nrm_sel = 1; end
        2: cnt_sel = 3;
        3: cnt_sel = 127;
        default: ;
      endcase
      configure(cnt_sel, nrm_sel);
      bursty = ($urandom_range(0, 2) != 0);
      recv_mode = $urandom_range(0, 3);
      budget = (cnt_sel > MAX_OVERSAMPLE) ? 40 : $urandom_range(60, 160);
      // receiver holds off while the sender keeps pushing, so the input backs up
      if (phase_no == 1) begin
        bursty = 1'b0;
        recv_mode = 0;
        holds_requested++;
      end
      eff = (cnt_sel == 0) ? 1 : cnt_sel;
      paused = 1'b0;
      phase_start = useful_items;
      while (useful_items - phase_start < budget) begin
        if (phase_no == 2 && !paused && useful_items - phase_start > budget / 2) begin
          wait_drained(0);
          paused = 1'b1;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // well-formed block, interleaved over neighboring channels, sometimes cut short
          blk = (eff > MAX_OVERSAMPLE) ? $urandom_range(1, MAX_OVERSAMPLE) : eff;
          nch = $urandom_range(1, 3);
          base_ch = $urandom_range(0, CHANNELS - 1);
          stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, blk - 1) : blk;
          for (int p = 0; p < stop_at; p++)
            for (int k = 0; k < nch; k++)
              send_item(make_item(FUNC_SAMPLE, p, base_ch + k, rand_sample(), $urandom()));
        end else if (r < 80) begin
          send_item(make_item(FUNC_SAMPLE, $urandom(), $urandom(), $urandom(), $urandom()));
        end else if (r < 88) begin
          send_item(make_item(FUNC_COEF, $urandom(), $urandom(), rand_coef(), $urandom()));
        end else if (r < 95) begin
          send_item(make_item(FUNC_CAL, $urandom(), $urandom(), rand_bias(), rand_scale()));
        end else begin
          send_item(make_item(FUNC_UNUSED, $urandom(), $urandom(), $urandom(), $urandom()));
        end
      end
      phase_no++;
    end

    wait_drained(SETTLE_CYCLES);
    sb.leftover();
    $display("run covered %0d items (%0d effective) over %0d random phases",
             total_items, useful_items, phase_no);
    $display("%0d filtered outputs checked, %0d of them clipped, %0d mismatches",
             sb.outputs_seen, sb.saturations, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/adfc_pkg.sv
rtl/adfc_ram.sv
rtl/adfc_front.sv
rtl/adfc_back.sv
rtl/adfc_scale.sv
rtl/adc_decimating_fir_calibrate.sv
rtl/adfc_checker.sv
test/testbench.sv
